FILE: design/tkbvc_pkg.sv
// Package for the touch key baseline and valve control block.
// Holds defaults, register widths and codes, control structs and state types.
// No dependencies.
package tkbvc_pkg;

  // default sizes of the block
  localparam int CAL_SAMPLES_DEF = 50;
  localparam int MEDIAN_TAPS_DEF = 3;

  // raw reading and baseline widths
  localparam int SAMPLE_W = 16;
  localparam int BASE_W   = 32;
  localparam int FRAC_W   = 16;

  // configuration register widths
  localparam int THR_W     = 16;
  localparam int BOOT_W    = 16;
  localparam int TIMEOUT_W = 20;
  localparam int WEIGHT_W  = 16;

  // timer widths
  localparam int UPTIME_W  = 16;
  localparam int ELAPSED_W = 21;

  // configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // register reset values
  localparam logic [THR_W-1:0]     THR_RST     = THR_W'(10);
  localparam logic [BOOT_W-1:0]    BOOT_RST    = BOOT_W'(10);
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(1200);
  localparam logic [WEIGHT_W-1:0]  SLOW_RST    = WEIGHT_W'(328);
  localparam logic [WEIGHT_W-1:0]  FAST_RST    = WEIGHT_W'(6554);

  // register indexes (word address)
  typedef enum logic [2:0] {
    REG_THRESHOLD = 3'd0,
    REG_BOOT      = 3'd1,
    REG_TIMEOUT   = 3'd2,
    REG_SLOW      = 3'd3,
    REG_FAST      = 3'd4
  } tkbvc_reg_t;

  // valve command codes
  typedef enum logic [1:0] {
    VALVE_NONE  = 2'd0,
    VALVE_OPEN  = 2'd1,
    VALVE_CLOSE = 2'd2
  } tkbvc_valve_t;

  // sequencing of calibration, baseline forming and normal running
  typedef enum logic [1:0] {
    ST_CAL,
    ST_FORM_LO,
    ST_FORM_HI,
    ST_RUN
  } tkbvc_state_t;

  // per key control from the top level
  typedef struct packed {
    logic                push;
    logic                accum;
    logic                form_lo;
    logic                form_hi;
    logic                track;
    logic [WEIGHT_W-1:0] weight;
    logic [THR_W-1:0]    threshold;
  } tkbvc_key_ctrl_t;

endpackage

FILE: design/tkbvc_key.sv
// One touch key channel: median window, touch detect, calibration sum,
// baseline forming by reciprocal multiply, and baseline tracking.
// Depends on tkbvc_pkg.
module tkbvc_key
  import tkbvc_pkg::*;
#(
  parameter int CAL_SAMPLES = CAL_SAMPLES_DEF,
  parameter int MEDIAN_TAPS = MEDIAN_TAPS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [SAMPLE_W-1:0] sample,
  input  tkbvc_key_ctrl_t     ctrl,
  output logic                touched
);

  // calibration sum and reciprocal of CAL_SAMPLES, exact for every sum
  localparam int SUM_W   = $clog2(CAL_SAMPLES * 65535 + 1);
  localparam int REC_S   = SUM_W + 24;
  localparam int REC_W   = REC_S + 1;
  localparam logic [63:0] RECIP = ((64'd1 << REC_S) + 64'(CAL_SAMPLES) - 64'd1)
                                  / 64'(CAL_SAMPLES);
  localparam int KL_W    = (REC_W + 1) / 2;
  localparam int FULL_W  = SUM_W + 2 * KL_W;
  localparam int PROD_W  = SUM_W + KL_W;
  localparam logic [KL_W-1:0] RECIP_LO = RECIP[KL_W-1:0];
  localparam logic [KL_W-1:0] RECIP_HI = KL_W'(RECIP >> KL_W);

  // median selection
  localparam int RANK_W = $clog2(MEDIAN_TAPS + 1);
  localparam int MID    = MEDIAN_TAPS / 2;

  logic [SAMPLE_W-1:0] win_r [MEDIAN_TAPS];
  logic [SAMPLE_W-1:0] win_new [MEDIAN_TAPS];
  logic [RANK_W-1:0]   rank [MEDIAN_TAPS];
  logic [SAMPLE_W-1:0] median;

  logic [SUM_W-1:0]    sum_r;
  logic [PROD_W-1:0]   plo_r;
  logic [KL_W-1:0]     recip_op;
  logic [PROD_W-1:0]   prod;
  logic [FULL_W-1:0]   full;

  logic [BASE_W-1:0]   base_r;
  logic [BASE_W-1:0]   base_nxt;
  logic [BASE_W-1:0]   target;
  logic [BASE_W-1:0]   diff;
  logic [BASE_W+WEIGHT_W-1:0] track_prod;
  logic [BASE_W-1:0]   delta;
  logic                rising;
  logic [SAMPLE_W:0]   lhs;

  // window after this item is pushed
  always_comb begin
    win_new[0] = sample;
    for (int i = 1; i < MEDIAN_TAPS; i++) begin
      win_new[i] = win_r[i-1];
    end
  end

  // stable rank of each tap, median is the tap of middle rank
  always_comb begin
    median = '0;
    for (int i = 0; i < MEDIAN_TAPS; i++) begin
      rank[i] = '0;
      for (int j = 0; j < MEDIAN_TAPS; j++) begin
        if (j != i) begin
          if (win_new[j] < win_new[i] || (win_new[j] == win_new[i] && j < i)) begin
            rank[i] = rank[i] + RANK_W'(1);
          end
        end
      end
      if (rank[i] == RANK_W'(MID)) begin
        median = median | win_new[i];
      end
    end
  end

  // touched when (median + threshold) in Q16.16 is below the baseline
  assign lhs     = {1'b0, median} + {1'b0, ctrl.threshold};
  assign touched = {lhs, {FRAC_W{1'b0}}} < {1'b0, base_r};

  // baseline forming: sum times reciprocal, split into two partial products
  assign recip_op = ctrl.form_hi ? RECIP_HI : RECIP_LO;
  assign prod     = PROD_W'(sum_r) * PROD_W'(recip_op);
  assign full     = (FULL_W'(prod) << KL_W) + FULL_W'(plo_r);

  // tracking step toward the median, truncated toward the old baseline
  assign target     = {median, {FRAC_W{1'b0}}};
  assign rising     = target >= base_r;
  assign diff       = rising ? (target - base_r) : (base_r - target);
  assign track_prod = (BASE_W+WEIGHT_W)'(diff) * (BASE_W+WEIGHT_W)'(ctrl.weight);
  assign delta      = track_prod[BASE_W+WEIGHT_W-1:WEIGHT_W];

  always_comb begin
    base_nxt = base_r;
    if (ctrl.form_hi) begin
      base_nxt = BASE_W'(full >> (SUM_W + 8));
    end else if (ctrl.track) begin
      base_nxt = rising ? (base_r + delta) : (base_r - delta);
    end
  end

  // window shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MEDIAN_TAPS; i++) begin
        win_r[i] <= '0;
      end
    end else if (ctrl.push) begin
      for (int i = 0; i < MEDIAN_TAPS; i++) begin
        win_r[i] <= win_new[i];
      end
    end
  end

  // calibration sum and baseline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      base_r <= '0;
    end else begin
      if (ctrl.accum) begin
        sum_r <= sum_r + SUM_W'(sample);
      end
      base_r <= base_nxt;
    end
  end

  // low partial product of the forming multiply
  always_ff @(posedge clk) begin
    if (ctrl.form_lo) begin
      plo_r <= prod;
    end
  end

endmodule

FILE: design/touch_key_baseline_valve_control_core.sv
// The result of an item is registered at the edge that accepts it.
// Throughput: one item per cycle; a result waiting on out_stall holds the input off.
// After the last calibration item the input stalls in ST_FORM_LO and ST_FORM_HI while
// each baseline is formed by a reciprocal multiply split into two partial products.
// Reset (rst_n, synchronous, active low) clears windows, sums, baselines, timers,
// restores register defaults and restarts calibration.
module touch_key_baseline_valve_control_core
  import tkbvc_pkg::*;
#(
  parameter int CAL_SAMPLES = CAL_SAMPLES_DEF,
  parameter int MEDIAN_TAPS = MEDIAN_TAPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SAMPLE_W-1:0]   in_touch_a,
  input  logic [SAMPLE_W-1:0]   in_touch_b,
  input  logic [SAMPLE_W-1:0]   in_touch_c,
  // result items
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_valve_command,
  output logic                  out_display_active,
  output logic                  out_calibrating,
  output logic                  out_key_b_touched,
  output logic                  out_key_c_touched,
  // configuration
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int NKEYS = 3;
  localparam int CNT_W = $clog2(CAL_SAMPLES + 1);

  // configuration registers
  logic [THR_W-1:0]     thr_r;
  logic [BOOT_W-1:0]    boot_r;
  logic [TIMEOUT_W-1:0] timeout_r;
  logic [WEIGHT_W-1:0]  slow_r;
  logic [WEIGHT_W-1:0]  fast_r;
  tkbvc_reg_t           reg_idx;
  logic                 cfg_wr;

  // sequencing
  tkbvc_state_t         state_r;
  tkbvc_state_t         state_nxt;
  logic                 forming;
  logic [CNT_W-1:0]     cnt_r;
  logic                 take;
  logic                 cal;
  logic                 run;

  // timers and valve state
  logic [UPTIME_W-1:0]  uptime_r;
  logic [UPTIME_W-1:0]  uptime_nxt;
  logic                 mopen_r;
  logic                 mopen_nxt;
  logic [ELAPSED_W-1:0] elapsed_r;
  logic [ELAPSED_W-1:0] elapsed_nxt;
  logic [ELAPSED_W-1:0] elapsed_inc;
  logic                 timeout_hit;
  tkbvc_valve_t         cmd;
  logic                 gate;

  // keys
  logic [SAMPLE_W-1:0]  sample [NKEYS];
  logic [NKEYS-1:0]     touched;
  tkbvc_key_ctrl_t      kctrl [NKEYS];

  // result register
  logic                 out_valid_r;
  tkbvc_valve_t         cmd_r;
  logic                 disp_r;
  logic                 cal_out_r;
  logic                 tb_r;
  logic                 tc_r;

  // handshake
  assign take     = in_valid & ~in_stall;
  assign in_stall = forming | (out_valid_r & out_stall);
  assign cal      = (state_r == ST_CAL);
  assign run      = (state_r == ST_RUN);

  // configuration write and read
  assign reg_idx    = tkbvc_reg_t'(cfg_paddr[CFG_ADDR_W-1:2]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= THR_RST;
      boot_r    <= BOOT_RST;
      timeout_r <= TIMEOUT_RST;
      slow_r    <= SLOW_RST;
      fast_r    <= FAST_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_THRESHOLD: thr_r     <= cfg_pwdata[THR_W-1:0];
        REG_BOOT:      boot_r    <= cfg_pwdata[BOOT_W-1:0];
        REG_TIMEOUT:   timeout_r <= cfg_pwdata[TIMEOUT_W-1:0];
        REG_SLOW:      slow_r    <= cfg_pwdata[WEIGHT_W-1:0];
        REG_FAST:      fast_r    <= cfg_pwdata[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_THRESHOLD: cfg_prdata = CFG_DATA_W'(thr_r);
      REG_BOOT:      cfg_prdata = CFG_DATA_W'(boot_r);
      REG_TIMEOUT:   cfg_prdata = CFG_DATA_W'(timeout_r);
      REG_SLOW:      cfg_prdata = CFG_DATA_W'(slow_r);
      REG_FAST:      cfg_prdata = CFG_DATA_W'(fast_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CAL;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and forming strobe
  always_comb begin
    state_nxt = state_r;
    forming   = 1'b0;
    unique case (state_r)
      ST_CAL: begin
        if (take && cnt_r == CNT_W'(CAL_SAMPLES - 1)) begin
          state_nxt = ST_FORM_LO;
        end
      end
      ST_FORM_LO: begin
        forming   = 1'b1;
        state_nxt = ST_FORM_HI;
      end
      ST_FORM_HI: begin
        forming   = 1'b1;
        state_nxt = ST_RUN;
      end
      ST_RUN: ;
      default: state_nxt = ST_CAL;
    endcase
  end

  // calibration item count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (take && cal) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // gate, timeout and valve commands for a running item
  assign gate        = touched[0] | (uptime_r < boot_r);
  assign elapsed_inc = (&elapsed_r) ? elapsed_r : (elapsed_r + ELAPSED_W'(1));
  assign timeout_hit = mopen_r & (elapsed_inc > ELAPSED_W'(timeout_r));

  always_comb begin
    cmd         = VALVE_NONE;
    mopen_nxt   = mopen_r;
    elapsed_nxt = elapsed_r;
    uptime_nxt  = (&uptime_r) ? uptime_r : (uptime_r + UPTIME_W'(1));
    if (mopen_r) begin
      elapsed_nxt = elapsed_inc;
      if (timeout_hit) begin
        mopen_nxt = 1'b0;
        cmd       = VALVE_CLOSE;
      end
    end
    if (gate && touched[1]) begin
      cmd         = VALVE_OPEN;
      mopen_nxt   = 1'b1;
      elapsed_nxt = '0;
    end
    if (gate && touched[2]) begin
      cmd         = VALVE_CLOSE;
      mopen_nxt   = 1'b0;
      elapsed_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uptime_r  <= '0;
      mopen_r   <= 1'b0;
      elapsed_r <= '0;
    end else if (take && run) begin
      uptime_r  <= uptime_nxt;
      mopen_r   <= mopen_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  // key channels
  assign sample[0] = in_touch_a;
  assign sample[1] = in_touch_b;
  assign sample[2] = in_touch_c;

  for (genvar k = 0; k < NKEYS; k++) begin : g_key
    always_comb begin
      kctrl[k].push      = take;
      kctrl[k].accum     = take & cal;
      kctrl[k].form_lo   = (state_r == ST_FORM_LO);
      kctrl[k].form_hi   = (state_r == ST_FORM_HI);
      kctrl[k].track     = take & run & (~gate | (k == 0) | touched[k]);
      kctrl[k].weight    = gate ? slow_r : fast_r;
      kctrl[k].threshold = thr_r;
    end

    tkbvc_key #(
      .CAL_SAMPLES (CAL_SAMPLES),
      .MEDIAN_TAPS (MEDIAN_TAPS)
    ) u_key (
      .clk     (clk),
      .rst_n   (rst_n),
      .sample  (sample[k]),
      .ctrl    (kctrl[k]),
      .touched (touched[k])
    );
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= take | (out_valid_r & out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (cal) begin
        cmd_r     <= VALVE_NONE;
        disp_r    <= 1'b0;
        cal_out_r <= 1'b1;
        tb_r      <= 1'b0;
        tc_r      <= 1'b0;
      end else begin
        cmd_r     <= cmd;
        disp_r    <= gate;
        cal_out_r <= 1'b0;
        tb_r      <= touched[1];
        tc_r      <= touched[2];
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_valve_command  = cmd_r;
  assign out_display_active = disp_r;
  assign out_calibrating    = cal_out_r;
  assign out_key_b_touched  = tb_r;
  assign out_key_c_touched  = tc_r;

endmodule
